// ===== design/stack_pattern_eraser_macros.svh =====
// ----------------------------------------------------------------------------
// stack pattern eraser assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef STACK_PATTERN_ERASER_MACROS_SVH
`define STACK_PATTERN_ERASER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define SPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPE_ASSERT(lbl, prop, msg)
`define SPE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// spe_pkg
// shared types, constants and helpers of the stack pattern eraser
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int unsigned STACK_DEPTH_DEFAULT = 4096;
  localparam int unsigned MAX_PATTERN_DEFAULT = 16;

  localparam int unsigned LEN_W   = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned DEPTH_W = 13;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PAT_CHARS = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic               func;
    logic [CHAR_W-1:0]  in_char;
    logic [INDEX_W-1:0] read_index;
  } spe_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  read_char;
    logic [DEPTH_W-1:0] stack_depth;
    logic               removed;
    logic               is_empty;
    logic               overflow;
  } spe_out_t;

  typedef struct packed {
    logic [LEN_W-1:0]                len;
    logic [PAT_CHARS*CHAR_W-1:0]     chars;
  } spe_pat_t;

  function automatic logic [CHAR_W-1:0] pat_char(
    input logic [PAT_CHARS*CHAR_W-1:0] chars,
    input logic [3:0]                  idx
  );
    pat_char = chars[idx*CHAR_W +: CHAR_W];
  endfunction

endpackage

// ===== design/spe_ram.sv =====
// ----------------------------------------------------------------------------
// spe_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module spe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/spe_cfg.sv =====
// ----------------------------------------------------------------------------
// spe_cfg
// pattern registers with length clamping
// ----------------------------------------------------------------------------
module spe_cfg #(
  parameter int unsigned MAX_PATTERN = spe_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spe_pkg::CFG_W-1:0]      cfg_wdata_i,
  output spe_pkg::spe_pat_t              pat_o
);

  logic [spe_pkg::LEN_W-1:0] len_q;
  logic [spe_pkg::CFG_W-1:0] low_q;
  logic [spe_pkg::CFG_W-1:0] high_q;
  logic [spe_pkg::LEN_W-1:0] len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= spe_pkg::LEN_W'(1);
      low_q  <= '0;
      high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spe_pkg::CFG_PATTERN_LENGTH: len_q  <= cfg_wdata_i[spe_pkg::LEN_W-1:0];
        spe_pkg::CFG_PATTERN_LOW:    low_q  <= cfg_wdata_i;
        spe_pkg::CFG_PATTERN_HIGH:   high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = spe_pkg::LEN_W'(1);
    end else if (len_q > spe_pkg::LEN_W'(MAX_PATTERN)) begin
      len_eff = spe_pkg::LEN_W'(MAX_PATTERN);
    end
  end

  assign pat_o.len   = len_eff;
  assign pat_o.chars = {high_q, low_q};

endmodule

// ===== design/stack_pattern_eraser.sv =====
// ----------------------------------------------------------------------------
// stack_pattern_eraser
// byte stack in ram that erases a configured pattern when it forms on top
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_data_i
//   out     | output    | out_valid_o / out_ready_i | out_data_o
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// a read whose index is below the depth goes via rdata to finish, others go
// straight; a push goes to finish, via cmp when it compares: one ram read
// port fetches one stacked byte per cycle and a mismatch stops early
// a new beat is taken while the previous result waits in the output register,
// the next result then holds in finish until that register drains
// no clearing pass after reset: entries are only read below the top
// ----------------------------------------------------------------------------
`include "stack_pattern_eraser_macros.svh"

module stack_pattern_eraser #(
  parameter int unsigned STACK_DEPTH = spe_pkg::STACK_DEPTH_DEFAULT,
  parameter int unsigned MAX_PATTERN = spe_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spe_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  spe_pkg::spe_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output spe_pkg::spe_out_t              out_data_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned XW = CW + spe_pkg::INDEX_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RDATA  = 2'd1;
  localparam logic [1:0] ST_CMP    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  spe_pkg::spe_pat_t pat;

  logic [1:0]                  state_q, state_d;
  logic [CW-1:0]               top_q, top_d;
  logic [3:0]                  cmp_j_q, cmp_j_d;
  logic [AW-1:0]               rd_addr_q, rd_addr_d;
  logic [spe_pkg::CHAR_W-1:0]  res_char_q, res_char_d;
  logic                        res_removed_q, res_removed_d;
  logic                        res_overflow_q, res_overflow_d;
  logic                        out_valid_q, out_valid_d;
  spe_pkg::spe_out_t           out_q, out_d;

  logic                        in_fire;
  logic                        mem_we;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [spe_pkg::CHAR_W-1:0]  mem_rdata;
  logic [spe_pkg::LEN_W-1:0]   len_m1;
  logic [spe_pkg::LEN_W-1:0]   cmp_idx;
  logic                        out_free;

  spe_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pat_o       (pat)
  );

  spe_ram #(
    .WIDTH (spe_pkg::CHAR_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (top_q[AW-1:0]),
    .wdata_i (in_data_i.in_char),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign len_m1     = pat.len - spe_pkg::LEN_W'(1);
  assign cmp_idx    = len_m1 - {1'b0, cmp_j_q};
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    top_d          = top_q;
    cmp_j_d        = cmp_j_q;
    rd_addr_d      = rd_addr_q;
    res_char_d     = res_char_q;
    res_removed_d  = res_removed_q;
    res_overflow_d = res_overflow_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_d          = out_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = rd_addr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_char_d     = '0;
          res_removed_d  = 1'b0;
          res_overflow_d = 1'b0;
          state_d        = ST_FINISH;
          if (in_data_i.func == spe_pkg::FUNC_READ) begin
            if (XW'(in_data_i.read_index) < XW'(top_q)) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(in_data_i.read_index);
              state_d   = ST_RDATA;
            end
          end else if (top_q >= CW'(STACK_DEPTH)) begin
            res_overflow_d = 1'b1;
          end else begin
            mem_we = 1'b1;
            top_d  = top_q + CW'(1);
            if (in_data_i.in_char == spe_pkg::pat_char(pat.chars, len_m1[3:0]) &&
                top_d >= CW'(pat.len)) begin
              if (pat.len == spe_pkg::LEN_W'(1)) begin
                top_d         = top_q;
                res_removed_d = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(top_q - CW'(1));
                rd_addr_d = AW'(top_q - CW'(1));
                cmp_j_d   = 4'd1;
                state_d   = ST_CMP;
              end
            end
          end
        end
      end
      ST_RDATA: begin
        res_char_d = mem_rdata;
        state_d    = ST_FINISH;
      end
      ST_CMP: begin
        if (mem_rdata != spe_pkg::pat_char(pat.chars, cmp_idx[3:0])) begin
          state_d = ST_FINISH;
        end else if ({1'b0, cmp_j_q} == len_m1) begin
          top_d         = top_q - CW'(pat.len);
          res_removed_d = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_addr_q - AW'(1);
          rd_addr_d = rd_addr_q - AW'(1);
          cmp_j_d   = cmp_j_q + 4'd1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_d.read_char   = res_char_q;
          out_d.stack_depth = spe_pkg::DEPTH_W'(top_q);
          out_d.removed     = res_removed_q;
          out_d.is_empty    = (top_q == '0);
          out_d.overflow    = res_overflow_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_j_q        <= cmp_j_d;
    rd_addr_q      <= rd_addr_d;
    res_char_q     <= res_char_d;
    res_removed_q  <= res_removed_d;
    res_overflow_q <= res_overflow_d;
    out_q          <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SPE_ASSERT(a_cmp_in_pattern, (state_q == ST_CMP) |-> ({1'b0, cmp_j_q} < pat.len), "compare index beyond pattern")
  `SPE_ASSERT(a_push_depth, (in_fire && in_data_i.func == spe_pkg::FUNC_PUSH && top_q < CW'(STACK_DEPTH)) |=> ((top_q == $past(top_q) + CW'(1)) || (top_q == $past(top_q))), "push moved depth wrongly")
  `SPE_ASSERT(a_out_from_finish, $rose(out_valid_o) |-> ($past(state_q) == ST_FINISH), "result loaded outside finish")
  `SPE_ASSERT_ALWAYS(a_depth_bound, !rst_ni || (top_q <= CW'(STACK_DEPTH)), "stack depth beyond capacity")

endmodule

// ===== sim/stack_pattern_eraser_test.sv =====
// ----------------------------------------------------------------------------
// stack_pattern_eraser_test
// pushes and reads bytes through the pattern eraser with random idling on
// both channels, keeps a local image of the byte stack and the pattern, and
// checks every output beat field by field against the predicted result
// ----------------------------------------------------------------------------
module stack_pattern_eraser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = spe_pkg::STACK_DEPTH_DEFAULT;
  localparam int unsigned MAXPAT       = spe_pkg::MAX_PATTERN_DEFAULT;
  localparam int unsigned MAX_WAIT     = 17;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned SWEEP_PHASES = 11;
  localparam int unsigned LIMIT_CYCLES = 1500000;

  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [spe_pkg::CFG_IDX_W-1:0] cfg_index = spe_pkg::CFG_PATTERN_LENGTH;
  logic [spe_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  spe_pkg::spe_in_t              in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  spe_pkg::spe_out_t             out_data;

  logic [spe_pkg::CHAR_W-1:0] kept_image [DEPTH];
  int unsigned                kept_count   = 0;
  logic [spe_pkg::LEN_W-1:0]  len_reg      = 5'd1;
  logic [spe_pkg::CFG_W-1:0]  pat_low_reg  = '0;
  logic [spe_pkg::CFG_W-1:0]  pat_high_reg = '0;

  spe_pkg::spe_out_t awaited_results [$];
  bit                gaps_on     = 1'b1;
  bit                stalls_on   = 1'b1;
  int unsigned       fail_count  = 0;
  int unsigned       cycle_count = 0;

  stack_pattern_eraser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned active_length();
    if (len_reg == 0) return 1;
    if (len_reg > MAXPAT) return MAXPAT;
    return 32'(len_reg);
  endfunction

  function automatic logic [spe_pkg::CHAR_W-1:0] pattern_byte(input int unsigned pos);
    logic [2*spe_pkg::CFG_W-1:0] chars;
    chars = {pat_high_reg, pat_low_reg};
    return chars[pos*spe_pkg::CHAR_W +: spe_pkg::CHAR_W];
  endfunction

  function automatic spe_pkg::spe_out_t predict_stack_op(input spe_pkg::spe_in_t beat);
    spe_pkg::spe_out_t res;
    int unsigned       len;
    bit                hit;
    res = '0;
    len = active_length();
    if (beat.func == spe_pkg::FUNC_PUSH) begin
      if (kept_count >= DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        kept_image[kept_count] = beat.in_char;
        kept_count++;
        if (beat.in_char == pattern_byte(len - 1) && kept_count >= len) begin
          hit = 1'b1;
          for (int j = 0; j < len; j++) begin
            if (kept_image[kept_count-1-j] != pattern_byte(len - 1 - j)) hit = 1'b0;
          end
          if (hit) begin
            kept_count -= len;
            res.removed = 1'b1;
          end
        end
      end
    end else if (beat.read_index < kept_count) begin
      res.read_char = kept_image[beat.read_index];
    end
    res.stack_depth = kept_count[spe_pkg::DEPTH_W-1:0];
    res.is_empty    = (kept_count == 0);
    return res;
  endfunction

  task automatic send_beat(input spe_pkg::spe_in_t beat);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(MAX_WAIT, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    awaited_results.insert(awaited_results.size(), predict_stack_op(beat));
  endtask

  task automatic push_byte(input logic [spe_pkg::CHAR_W-1:0] ch);
    spe_pkg::spe_in_t beat;
    beat.func       = spe_pkg::FUNC_PUSH;
    beat.in_char    = ch;
    beat.read_index = spe_pkg::INDEX_W'($urandom_range(DEPTH - 1, 0));
    send_beat(beat);
  endtask

  task automatic read_entry(input logic [spe_pkg::INDEX_W-1:0] idx);
    spe_pkg::spe_in_t beat;
    beat.func       = spe_pkg::FUNC_READ;
    beat.in_char    = spe_pkg::CHAR_W'($urandom_range(255, 0));
    beat.read_index = idx;
    send_beat(beat);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_pattern(input logic [spe_pkg::CFG_W-1:0] len_word, low_word, high_word);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= spe_pkg::CFG_PATTERN_LENGTH;
    cfg_wdata <= len_word;
    @(posedge clk_i);
    cfg_index <= spe_pkg::CFG_PATTERN_LOW;
    cfg_wdata <= low_word;
    @(posedge clk_i);
    cfg_index <= spe_pkg::CFG_PATTERN_HIGH;
    cfg_wdata <= high_word;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    len_reg      = len_word[spe_pkg::LEN_W-1:0];
    pat_low_reg  = low_word;
    pat_high_reg = high_word;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic compare_field(input string label,
                               input logic [spe_pkg::DEPTH_W-1:0] want, got);
    if (got !== want) begin
      $display("%0t %s: expected %0h actual %0h", $time, label, want, got);
      fail_count++;
    end
  endtask

  task automatic test_reset_defaults();
    read_entry('0);
    read_entry(spe_pkg::INDEX_W'(DEPTH - 1));
    push_byte(8'h00);
    push_byte(8'hFF);
    read_entry('0);
    read_entry(spe_pkg::INDEX_W'(DEPTH - 1));
    push_byte(8'h00);
  endtask

  task automatic test_nested_erase();
    load_pattern(64'd3, 64'h0000_0000_0063_6261, '1);
    // short stack, no compare for the first byte; the inner, then the outer pattern is erased
    push_byte(8'h63);
    push_byte(8'h61);
    push_byte(8'h62);
    push_byte(8'h61);
    push_byte(8'h62);
    push_byte(8'h63);
    push_byte(8'h63);
    read_entry(spe_pkg::INDEX_W'(1));
  endtask

  task automatic test_length_clamp();
    load_pattern(64'd0, 64'h0000_0000_0000_00FF, '0);
    push_byte(8'hFF);
    load_pattern({59'h5A5_A5A5_A5A5_A5A5, 5'd31}, 64'h0123_4567_89AB_CDEF,
                 64'h77FE_DCBA_9876_5432);
    push_byte(8'h77);
    load_pattern(64'd17, 64'h1111_2222_3333_4444, 64'h5500_6600_7700_8800);
    push_byte(8'h55);
  endtask

  task automatic test_random_sweeps();
    int unsigned                 phase, len, pick, cut, sent, budget, len_sel;
    bit                          few_symbols;
    logic [spe_pkg::CHAR_W-1:0]  sym_a, sym_b;
    logic [2*spe_pkg::CFG_W-1:0] chars;
    logic [spe_pkg::CFG_W-1:0]   len_word;
    budget = RANDOM_ITEMS / SWEEP_PHASES;
    for (phase = 0; phase < SWEEP_PHASES; phase++) begin
      case (phase)
        0: len_sel = 1;
        1: len_sel = 3;
        2: len_sel = 16;
        3: len_sel = 0;
        4: len_sel = 31;
        5: len_sel = 2;
        6: len_sel = 17;
        7: len_sel = 5;
        8: len_sel = 8;
        default: len_sel = $urandom_range(15, 2);
      endcase
      len_word = {$urandom(), $urandom()};
      if (phase % 2 == 0) len_word[spe_pkg::CFG_W-1:spe_pkg::LEN_W] = '0;
      len_word[spe_pkg::LEN_W-1:0] = len_sel[spe_pkg::LEN_W-1:0];
      few_symbols = (phase % 2 == 0);
      sym_a = spe_pkg::CHAR_W'($urandom_range(255, 0));
      sym_b = spe_pkg::CHAR_W'($urandom_range(255, 0));
      chars = {$urandom(), $urandom(), $urandom(), $urandom()};
      if (few_symbols) begin
        for (int k = 0; k < 2 * spe_pkg::CFG_W / spe_pkg::CHAR_W; k++) begin
          chars[k*spe_pkg::CHAR_W +: spe_pkg::CHAR_W] = $urandom_range(1, 0) ? sym_a : sym_b;
        end
      end
      load_pattern(len_word, chars[spe_pkg::CFG_W-1:0],
                   chars[2*spe_pkg::CFG_W-1:spe_pkg::CFG_W]);
      gaps_on   = (phase % 3) != 1;
      stalls_on = (phase % 4) != 2;
      len  = active_length();
      sent = 0;
      while (sent < budget) begin
        pick = $urandom_range(99, 0);
        if (pick < 30) begin
          for (int k = 0; k < len; k++) push_byte(pattern_byte(k));
          sent += len;
        end else if (pick < 45) begin
          cut = $urandom_range(len - 1, 0);
          for (int k = 0; k < cut; k++) push_byte(pattern_byte(k));
          sent += cut;
        end else if (pick < 60) begin
          cut = $urandom_range(len - 1, 0);
          for (int k = cut; k < len; k++) push_byte(pattern_byte(k));
          sent += len - cut;
        end else if (pick < 70) begin
          push_byte(pattern_byte($urandom_range(len - 1, 0)));
          sent++;
        end else if (pick < 80) begin
          if (few_symbols && $urandom_range(1, 0)) push_byte($urandom_range(1, 0) ? sym_a : sym_b);
          else push_byte(spe_pkg::CHAR_W'($urandom_range(255, 0)));
          sent++;
        end else if (pick < 92) begin
          read_entry(spe_pkg::INDEX_W'(kept_count == 0 ? 0 : $urandom_range(kept_count - 1, 0)));
          sent++;
        end else begin
          read_entry(spe_pkg::INDEX_W'($urandom_range(DEPTH - 1, 0)));
          sent++;
        end
      end
    end
  endtask

  initial begin : result_checker
    spe_pkg::spe_out_t got, want;
    int unsigned       stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = stalls_on ? $urandom_range(MAX_WAIT, 0) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (out_valid !== 1'b1);
      got = out_data;
      if (awaited_results.size() == 0) begin
        $display("%0t result beat: expected none actual %h", $time, got);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("read_char", spe_pkg::DEPTH_W'(want.read_char),
                      spe_pkg::DEPTH_W'(got.read_char));
        compare_field("stack_depth", want.stack_depth, got.stack_depth);
        compare_field("removed", spe_pkg::DEPTH_W'(want.removed),
                      spe_pkg::DEPTH_W'(got.removed));
        compare_field("is_empty", spe_pkg::DEPTH_W'(want.is_empty),
                      spe_pkg::DEPTH_W'(got.is_empty));
        compare_field("overflow", spe_pkg::DEPTH_W'(want.overflow),
                      spe_pkg::DEPTH_W'(got.overflow));
      end
    end
  end

  initial begin : cycle_watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_nested_erase();
    test_length_clamp();
    test_random_sweeps();
    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
